[src/spot_pkg.sv]
// Package for the shape pair overlap test: shape kinds, pairing codes and default sizes.
package spot_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_RECT    = 2'd1,
    KIND_CIRCLE  = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  // Ordered pairing of two shapes, lower kind first.
  typedef enum logic [2:0] {
    PAIR_NONE,
    PAIR_PT_RECT,
    PAIR_PT_CIRC,
    PAIR_RECT_RECT,
    PAIR_RECT_CIRC,
    PAIR_CIRC_CIRC
  } pair_t;

endpackage

[src/shape_pair_overlap_test_unit.sv]
// Top level of the shape pair overlap test: input register, overlap logic, result register.
//
// Usage: each transfer on the input channel carries two shapes (kind, centre, width and
// height each). A shape is a point, a centre-based rectangle or a circle whose diameter is
// the larger of its width and height. For every input transfer exactly one result transfer
// follows, in order, carrying out_hit (the shapes overlap or touch) and out_unsupported
// (a point-point pair or an invalid kind code, always with out_hit low).
//
// A pair accepted at a clock edge is captured in the input register, evaluated by one
// combinational pass and loaded into the result register as soon as that register is
// empty or being read out; its result transfer is then offered on the output channel.
// Throughput is one pair per cycle unless out_ready stalls; the two registers form a
// two-entry pipeline, so a new pair is taken while a result still waits.
//
// When the receiver stalls (out_ready low), the result holds and the pair behind it stays
// in the input register; in_ready drops only when both registers are full.
// Reset (rst_n low at a clock edge) empties both registers; no result is pending after it.
//
// The arithmetic works on doubled coordinates so half sizes stay exact, and it compares
// squared distances, so no roots or divisions are needed.
module shape_pair_overlap_test_unit #(
  parameter int unsigned COORD_BITS = spot_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_left_kind,
  input  logic signed [COORD_BITS-1:0] in_left_x,
  input  logic signed [COORD_BITS-1:0] in_left_y,
  input  logic [COORD_BITS-1:0]        in_left_w,
  input  logic [COORD_BITS-1:0]        in_left_h,
  input  logic [1:0]                   in_right_kind,
  input  logic signed [COORD_BITS-1:0] in_right_x,
  input  logic signed [COORD_BITS-1:0] in_right_y,
  input  logic [COORD_BITS-1:0]        in_right_w,
  input  logic [COORD_BITS-1:0]        in_right_h,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic                         out_unsupported
);

  localparam int unsigned N = COORD_BITS;

  // Input register.
  logic                   s1_valid_r;
  spot_pkg::kind_t        l_kind_r, r_kind_r;
  logic signed [N-1:0]    l_x_r, l_y_r, r_x_r, r_y_r;
  logic [N-1:0]           l_w_r, l_h_r, r_w_r, r_h_r;

  // Result register.
  logic                   out_valid_r;
  logic                   hit_r, unsup_r;
  logic                   hit_nxt, unsup_nxt;

  logic                   s2_ready;
  logic                   s1_ready;
  logic                   in_xfer;
  logic                   s2_load;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign in_xfer  = in_valid && s1_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      l_kind_r <= spot_pkg::kind_t'(in_left_kind);
      l_x_r    <= in_left_x;
      l_y_r    <= in_left_y;
      l_w_r    <= in_left_w;
      l_h_r    <= in_left_h;
      r_kind_r <= spot_pkg::kind_t'(in_right_kind);
      r_x_r    <= in_right_x;
      r_y_r    <= in_right_y;
      r_w_r    <= in_right_w;
      r_h_r    <= in_right_h;
    end
  end

  // Order the pair so that shape a has the lower kind code.
  logic                swap;
  spot_pkg::kind_t     a_kind, b_kind;
  logic signed [N-1:0] a_x, a_y, b_x, b_y;
  logic [N-1:0]        a_w, a_h, b_w, b_h;
  logic [N-1:0]        a_d, b_d;

  assign swap   = (r_kind_r < l_kind_r);
  assign a_kind = swap ? r_kind_r : l_kind_r;
  assign b_kind = swap ? l_kind_r : r_kind_r;
  assign a_x    = swap ? r_x_r : l_x_r;
  assign a_y    = swap ? r_y_r : l_y_r;
  assign a_w    = swap ? r_w_r : l_w_r;
  assign a_h    = swap ? r_h_r : l_h_r;
  assign b_x    = swap ? l_x_r : r_x_r;
  assign b_y    = swap ? l_y_r : r_y_r;
  assign b_w    = swap ? l_w_r : r_w_r;
  assign b_h    = swap ? l_h_r : r_h_r;
  assign a_d    = (a_w > a_h) ? a_w : a_h;
  assign b_d    = (b_w > b_h) ? b_w : b_h;

  // Classify the ordered pair. Anything with an invalid code or two points is unsupported.
  spot_pkg::pair_t pair;

  always_comb begin
    pair = spot_pkg::PAIR_NONE;
    unique case (a_kind)
      spot_pkg::KIND_POINT: begin
        if (b_kind == spot_pkg::KIND_RECT) begin
          pair = spot_pkg::PAIR_PT_RECT;
        end else if (b_kind == spot_pkg::KIND_CIRCLE) begin
          pair = spot_pkg::PAIR_PT_CIRC;
        end
      end
      spot_pkg::KIND_RECT: begin
        if (b_kind == spot_pkg::KIND_RECT) begin
          pair = spot_pkg::PAIR_RECT_RECT;
        end else if (b_kind == spot_pkg::KIND_CIRCLE) begin
          pair = spot_pkg::PAIR_RECT_CIRC;
        end
      end
      spot_pkg::KIND_CIRCLE: begin
        if (b_kind == spot_pkg::KIND_CIRCLE) begin
          pair = spot_pkg::PAIR_CIRC_CIRC;
        end
      end
      default: pair = spot_pkg::PAIR_NONE;
    endcase
  end

  // Absolute centre distances in doubled units. The raw difference needs one extra bit;
  // its magnitude fits unsigned in the same width, and doubling adds one more.
  logic signed [N:0] dx_raw, dy_raw;
  logic [N:0]        adx_raw, ady_raw;
  logic [N+1:0]      adx, ady;

  assign dx_raw  = {a_x[N-1], a_x} - {b_x[N-1], b_x};
  assign dy_raw  = {a_y[N-1], a_y} - {b_y[N-1], b_y};
  assign adx_raw = dx_raw[N] ? (~dx_raw + 1'b1) : dx_raw;
  assign ady_raw = dy_raw[N] ? (~dy_raw + 1'b1) : dy_raw;
  assign adx     = {adx_raw, 1'b0};
  assign ady     = {ady_raw, 1'b0};

  // Half extents that count: a point contributes none, and only a rectangle is a box.
  logic [N-1:0] aw_eff, ah_eff, bw_eff, bh_eff;
  logic [N-1:0] grow;

  assign aw_eff = (a_kind == spot_pkg::KIND_RECT) ? a_w : '0;
  assign ah_eff = (a_kind == spot_pkg::KIND_RECT) ? a_h : '0;
  assign bw_eff = (b_kind == spot_pkg::KIND_RECT) ? b_w : '0;
  assign bh_eff = (b_kind == spot_pkg::KIND_RECT) ? b_h : '0;
  // A rectangle against a circle is grown by the circle diameter in one axis at a time.
  assign grow   = (pair == spot_pkg::PAIR_RECT_CIRC) ? b_d : '0;

  logic [N+1:0] box_w, box_h, box_wg, box_hg;
  logic         box_hit;

  assign box_w   = {2'b00, aw_eff} + {2'b00, bw_eff};
  assign box_h   = {2'b00, ah_eff} + {2'b00, bh_eff};
  assign box_wg  = box_w + {2'b00, grow};
  assign box_hg  = box_h + {2'b00, grow};
  assign box_hit = ((adx <= box_w) && (ady <= box_hg)) ||
                   ((adx <= box_wg) && (ady <= box_h));

  // Distance test. With a rectangle as shape a, the offset to its nearest corner is the
  // absolute distance less the half extent; otherwise the extent is zero and this is the
  // plain centre distance.
  logic signed [N+2:0]   ex, ey;
  logic signed [2*N+5:0] sq_x, sq_y;
  logic [2*N+3:0]        dist_sq;
  logic [N:0]            diam;
  logic [2*N+1:0]        diam_sq;
  logic                  near_hit;

  assign ex      = $signed({1'b0, adx}) - $signed({3'b000, aw_eff});
  assign ey      = $signed({1'b0, ady}) - $signed({3'b000, ah_eff});
  assign sq_x    = ex * ex;
  assign sq_y    = ey * ey;
  assign dist_sq = {1'b0, sq_x[2*N+2:0]} + {1'b0, sq_y[2*N+2:0]};
  assign diam    = (pair == spot_pkg::PAIR_CIRC_CIRC) ? ({1'b0, a_d} + {1'b0, b_d})
                                                      : {1'b0, b_d};
  assign diam_sq = diam * diam;
  assign near_hit = (dist_sq <= {2'b00, diam_sq});

  always_comb begin
    case (pair) inside
      spot_pkg::PAIR_PT_RECT, spot_pkg::PAIR_RECT_RECT: hit_nxt = box_hit;
      spot_pkg::PAIR_RECT_CIRC:                         hit_nxt = box_hit || near_hit;
      spot_pkg::PAIR_PT_CIRC, spot_pkg::PAIR_CIRC_CIRC: hit_nxt = near_hit;
      default:                                          hit_nxt = 1'b0;
    endcase
    unsup_nxt = (pair == spot_pkg::PAIR_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      hit_r   <= hit_nxt;
      unsup_r <= unsup_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_unsupported = unsup_r;

endmodule

[src/spot_checker.sv]
// Port-level checker for the shape pair overlap test, bound to the top level.
module spot_checker #(
  parameter int unsigned COORD_BITS = spot_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_left_kind,
  input logic [1:0]            in_right_kind,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_hit,
  input logic                  out_unsupported
);

  logic pp_pair;

  assign pp_pair = (in_left_kind == spot_pkg::KIND_POINT) &&
                   (in_right_kind == spot_pkg::KIND_POINT);

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // Input backpressure only comes from a stalled, full result side.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the result side can move");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) &&
                                   $stable(out_unsupported)))
    else $error("stalled result changed");

  // An unsupported pair never reports a hit.
  a_unsup_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unsupported) |-> !out_hit)
    else $error("unsupported result with hit set");

  // A point-point pair shows up as unsupported on the result register when the output flows.
  a_pp_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && pp_pair) ##1 out_ready |=>
      (out_valid && out_unsupported && !out_hit))
    else $error("point-point pair not reported as unsupported");

endmodule

bind shape_pair_overlap_test_unit spot_checker #(
  .COORD_BITS(COORD_BITS)
) u_spot_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_left_kind    (in_left_kind),
  .in_right_kind   (in_right_kind),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_hit         (out_hit),
  .out_unsupported (out_unsupported)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the shape pair overlap unit: directed pairs, random pairs, checker.
module tb_top;

  localparam int CB = spot_pkg::COORD_BITS_DEF;
  // Printing stops after this many reported mismatches; counting goes on.
  localparam int PRINT_LIMIT = 100;

  // One shape as it travels on the input channel.
  typedef struct {
    spot_pkg::kind_t       kind;
    logic signed [CB-1:0]  x;
    logic signed [CB-1:0]  y;
    logic [CB-1:0]         w;
    logic [CB-1:0]         h;
  } shape_t;

  // One result transfer: the two flags the block reports for a pair.
  typedef struct {
    bit hit;
    bit unsupported;
  } overlap_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_left_kind;
  logic signed [CB-1:0] in_left_x;
  logic signed [CB-1:0] in_left_y;
  logic [CB-1:0]        in_left_w;
  logic [CB-1:0]        in_left_h;
  logic [1:0]           in_right_kind;
  logic signed [CB-1:0] in_right_x;
  logic signed [CB-1:0] in_right_y;
  logic [CB-1:0]        in_right_w;
  logic [CB-1:0]        in_right_h;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_hit;
  logic                 out_unsupported;

  // Predicted results, oldest first, one per accepted pair.
  overlap_t expected_overlaps[$];
  int       mismatch_count = 0;
  // Idle rates in percent of cycles for the sender and the receiver.
  int       send_idle = 0;
  int       recv_idle = 0;

  shape_pair_overlap_test_unit #(.COORD_BITS(CB)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_kind    (in_left_kind),
    .in_left_x       (in_left_x),
    .in_left_y       (in_left_y),
    .in_left_w       (in_left_w),
    .in_left_h       (in_left_h),
    .in_right_kind   (in_right_kind),
    .in_right_x      (in_right_x),
    .in_right_y      (in_right_y),
    .in_right_w      (in_right_w),
    .in_right_h      (in_right_h),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_unsupported (out_unsupported)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Overlap predictor. Every position is doubled so that half sizes are whole
  // numbers: a rectangle spans 2x - w .. 2x + w. Circle tests compare squared
  // doubled distances with a squared diameter, so no root is ever taken. The
  // 64-bit arithmetic holds every intermediate, and all bounds are inclusive,
  // which makes touching shapes count as overlapping.
  // ---------------------------------------------------------------------------

  function automatic longint twice(logic signed [CB-1:0] v);
    return 2 * longint'(v);
  endfunction

  function automatic longint diameter(shape_t s);
    return (s.w > s.h) ? longint'(s.w) : longint'(s.h);
  endfunction

  // Doubled point inside a box with doubled centre and full size, bounds inclusive.
  function automatic bit in_box(longint px, longint py, longint cx, longint cy,
                                longint hw, longint hh);
    return px >= cx - hw && px <= cx + hw && py >= cy - hh && py <= cy + hh;
  endfunction

  // Two doubled points no farther apart than diameter d allows.
  function automatic bit near(longint ax, longint ay, longint bx, longint by, longint d);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy <= d * d;
  endfunction

  // The rectangle is grown by the circle's diameter along each axis in turn;
  // what is left uncovered near the corners is tested against corner circles.
  function automatic bit rect_touches_circle(shape_t r, shape_t c);
    longint d;
    longint cx;
    longint cy;
    longint rx;
    longint ry;
    longint rw;
    longint rh;
    d  = diameter(c);
    cx = twice(c.x);
    cy = twice(c.y);
    rx = twice(r.x);
    ry = twice(r.y);
    rw = longint'(r.w);
    rh = longint'(r.h);
    return in_box(cx, cy, rx, ry, rw, rh + d) || in_box(cx, cy, rx, ry, rw + d, rh) ||
           near(cx, cy, rx - rw, ry - rh, d) || near(cx, cy, rx + rw, ry - rh, d) ||
           near(cx, cy, rx - rw, ry + rh, d) || near(cx, cy, rx + rw, ry + rh, d);
  endfunction

  // Shape a has the lower or equal kind; both kinds are valid and not both points.
  function automatic bit shapes_overlap(shape_t a, shape_t b);
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint aw;
    longint ah;
    longint bw;
    longint bh;
    ax = twice(a.x);
    ay = twice(a.y);
    bx = twice(b.x);
    by = twice(b.y);
    aw = longint'(a.w);
    ah = longint'(a.h);
    bw = longint'(b.w);
    bh = longint'(b.h);
    if (a.kind == spot_pkg::KIND_POINT && b.kind == spot_pkg::KIND_RECT)
      return in_box(ax, ay, bx, by, bw, bh);
    if (a.kind == spot_pkg::KIND_POINT) return near(ax, ay, bx, by, diameter(b));
    if (a.kind == spot_pkg::KIND_RECT && b.kind == spot_pkg::KIND_RECT) begin
      return ax - aw <= bx + bw && ax + aw >= bx - bw &&
             ay - ah <= by + bh && ay + ah >= by - bh;
    end
    if (a.kind == spot_pkg::KIND_RECT) return rect_touches_circle(a, b);
    return near(ax, ay, bx, by, diameter(a) + diameter(b));
  endfunction

  function automatic overlap_t predict_overlap(shape_t l, shape_t r);
    overlap_t res;
    res.unsupported = l.kind == spot_pkg::KIND_INVALID || r.kind == spot_pkg::KIND_INVALID ||
                      (l.kind == spot_pkg::KIND_POINT && r.kind == spot_pkg::KIND_POINT);
    res.hit = 1'b0;
    if (!res.unsupported) begin
      res.hit = (l.kind <= r.kind) ? shapes_overlap(l, r) : shapes_overlap(r, l);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic shape_t mk(spot_pkg::kind_t k, int x, int y, int w, int h);
    shape_t s;
    s.kind = k;
    s.x    = x[CB-1:0];
    s.y    = y[CB-1:0];
    s.w    = w[CB-1:0];
    s.h    = h[CB-1:0];
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t ERROR: %s", $time, msg);
  endtask

  // Sends one pair. The task is entered just after a rising edge and returns just
  // after the edge at which the pair was taken. Idle cycles come first, so valid is
  // never lowered once it is raised for this pair. The ready decision is sampled at
  // the falling edge, where all inputs and outputs are settled, and that decision is
  // what the next rising edge acts upon.
  task automatic send_pair(input shape_t l, input shape_t r);
    bit taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_left_kind  <= l.kind;
    in_left_x     <= l.x;
    in_left_y     <= l.y;
    in_left_w     <= l.w;
    in_left_h     <= l.h;
    in_right_kind <= r.kind;
    in_right_x    <= r.x;
    in_right_y    <= r.y;
    in_right_w    <= r.w;
    in_right_h    <= r.h;
    do begin
      @(negedge clk);
      taken = in_ready;
      if (taken) expected_overlaps.insert(expected_overlaps.size(), predict_overlap(l, r));
      @(posedge clk);
    end while (!taken);
  endtask

  // The receiver takes each result with the chance set by recv_idle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Result checker. As for the sender, a transfer seen valid and ready at the
  // falling edge is the one taken at the following rising edge.
  always @(negedge clk) begin
    overlap_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_overlaps.size() == 0) begin
        report_mismatch($sformatf("result transfer with no pair pending (hit %0b unsupported %0b)",
                                  out_hit, out_unsupported));
      end else begin
        want = expected_overlaps.pop_front();
        if (out_hit !== want.hit)
          report_mismatch($sformatf("out_hit is %0b, predicted %0b", out_hit, want.hit));
        if (out_unsupported !== want.unsupported)
          report_mismatch($sformatf("out_unsupported is %0b, predicted %0b",
                                    out_unsupported, want.unsupported));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Point against point and invalid kinds on either side never report a hit,
  // even where the shapes sit on top of each other.
  task automatic test_unsupported_pairs();
    send_pair(mk(spot_pkg::KIND_POINT, 0, 0, 0, 0), mk(spot_pkg::KIND_POINT, 0, 0, 0, 0));
    send_pair(mk(spot_pkg::KIND_INVALID, 5, 5, 10, 10), mk(spot_pkg::KIND_RECT, 5, 5, 10, 10));
    send_pair(mk(spot_pkg::KIND_CIRCLE, -7, 3, 9, 2), mk(spot_pkg::KIND_INVALID, -7, 3, 9, 2));
    send_pair(mk(spot_pkg::KIND_INVALID, 0, 0, 1, 1), mk(spot_pkg::KIND_INVALID, 0, 0, 1, 1));
  endtask

  // Points carry sizes that must be ignored; the boundary cases sit exactly on
  // and just past an edge, in both orders of the pair.
  task automatic test_point_pairs();
    send_pair(mk(spot_pkg::KIND_POINT, 10, 0, 65535, 65535), mk(spot_pkg::KIND_RECT, 0, 0, 20, 2));
    send_pair(mk(spot_pkg::KIND_RECT, 0, 0, 20, 2), mk(spot_pkg::KIND_POINT, 11, 0, 65535, 0));
    send_pair(mk(spot_pkg::KIND_POINT, 3, 4, 0, 0), mk(spot_pkg::KIND_CIRCLE, 0, 0, 10, 0));
    send_pair(mk(spot_pkg::KIND_CIRCLE, 0, 0, 0, 9), mk(spot_pkg::KIND_POINT, 3, 4, 123, 45));
    send_pair(mk(spot_pkg::KIND_POINT, 0, -1, 0, 0), mk(spot_pkg::KIND_RECT, 0, 0, 0, 2));
  endtask

  // Zero-size rectangles and circles act as their centre point.
  task automatic test_zero_size();
    send_pair(mk(spot_pkg::KIND_RECT, 4, 4, 0, 0), mk(spot_pkg::KIND_RECT, 4, 4, 0, 0));
    send_pair(mk(spot_pkg::KIND_RECT, 4, 4, 0, 0), mk(spot_pkg::KIND_RECT, 5, 4, 0, 0));
    send_pair(mk(spot_pkg::KIND_CIRCLE, -2, 9, 0, 0), mk(spot_pkg::KIND_CIRCLE, -2, 9, 0, 0));
    send_pair(mk(spot_pkg::KIND_CIRCLE, -2, 9, 0, 0), mk(spot_pkg::KIND_POINT, -2, 9, 0, 0));
  endtask

  // Rectangle against circle: the corner region just in and just out of reach,
  // the grown edge touched exactly, and circle against circle touching and just apart.
  task automatic test_curved_pairs();
    send_pair(mk(spot_pkg::KIND_RECT, 0, 0, 4, 4), mk(spot_pkg::KIND_CIRCLE, 4, 4, 5, 0));
    send_pair(mk(spot_pkg::KIND_RECT, 0, 0, 4, 4), mk(spot_pkg::KIND_CIRCLE, 4, 4, 6, 3));
    send_pair(mk(spot_pkg::KIND_CIRCLE, 4, -4, 0, 6), mk(spot_pkg::KIND_RECT, 0, 0, 4, 4));
    send_pair(mk(spot_pkg::KIND_CIRCLE, 5, 0, 6, 6), mk(spot_pkg::KIND_RECT, 0, 0, 4, 4));
    send_pair(mk(spot_pkg::KIND_CIRCLE, 0, 0, 4, 1), mk(spot_pkg::KIND_CIRCLE, 4, 0, 2, 4));
    send_pair(mk(spot_pkg::KIND_CIRCLE, 0, 0, 3, 0), mk(spot_pkg::KIND_CIRCLE, 0, 4, 4, 4));
  endtask

  // Field extremes: corners of the coordinate range with the largest sizes.
  task automatic test_field_extremes();
    send_pair(mk(spot_pkg::KIND_RECT, -32768, -32768, 65535, 65535),
              mk(spot_pkg::KIND_RECT, 32767, 32767, 65535, 65535));
    send_pair(mk(spot_pkg::KIND_CIRCLE, 32767, -32768, 0, 65535),
              mk(spot_pkg::KIND_CIRCLE, -32768, 32767, 65535, 0));
    send_pair(mk(spot_pkg::KIND_POINT, -32768, 32767, 65535, 65535),
              mk(spot_pkg::KIND_RECT, 32767, -32768, 65535, 65535));
    send_pair(mk(spot_pkg::KIND_RECT, 32767, 32767, 65535, 65535),
              mk(spot_pkg::KIND_CIRCLE, -32768, -32768, 65535, 65535));
  endtask

  function automatic spot_pkg::kind_t pick_kind();
    int r;
    r = $urandom_range(19);
    return (r == 0) ? spot_pkg::KIND_INVALID : spot_pkg::kind_t'(r % 3);
  endfunction

  // Mostly small sizes so that pairs land on both sides of the boundary;
  // now and then the full range.
  function automatic int pick_size();
    case ($urandom_range(3))
      0: return $urandom_range(8);
      1: return $urandom_range(100);
      2: return $urandom_range(2000);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Most pairs place the second shape within a span of the first that is about
  // twice the distance at which they stop touching, so hits and misses mix. The
  // rest are fully random fields, which toggle every input bit.
  task automatic test_random_pairs(input int count);
    shape_t l;
    shape_t r;
    int     span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        l = mk(spot_pkg::kind_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        r = mk(spot_pkg::kind_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        l = mk(pick_kind(), $urandom, $urandom, pick_size(), pick_size());
        r = mk(pick_kind(), 0, 0, pick_size(), pick_size());
        span = int'(l.w) + int'(l.h) + int'(r.w) + int'(r.h) + 2;
        r.x = CB'(int'(l.x) + int'($urandom_range(2 * span)) - span);
        r.y = CB'(int'(l.y) + int'($urandom_range(2 * span)) - span);
      end
      send_pair(l, r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_left_kind  = spot_pkg::KIND_POINT;
    in_left_x     = '0;
    in_left_y     = '0;
    in_left_w     = '0;
    in_left_h     = '0;
    in_right_kind = spot_pkg::KIND_POINT;
    in_right_x    = '0;
    in_right_y    = '0;
    in_right_w    = '0;
    in_right_h    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The sender idles now and then while the receiver stalls more often than not.
    send_idle = 19;
    recv_idle = 55;
    test_unsupported_pairs();
    test_point_pairs();
    test_zero_size();
    test_curved_pairs();
    test_field_extremes();
    test_random_pairs(340);

    // Roles swapped: a slow sender and an eager receiver.
    send_idle = 55;
    recv_idle = 19;
    test_random_pairs(340);

    // Back to back at full rate.
    send_idle = 0;
    recv_idle = 0;
    test_random_pairs(345);

    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && expected_overlaps.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_overlaps.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_overlaps.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
src/spot_pkg.sv
src/shape_pair_overlap_test_unit.sv
src/spot_checker.sv
tb/sv/tb_top.sv
